@@ sv/tch_pkg.sv @@
// ============================================================================
// tch_pkg
// Shared constants and the arctangent table for the tilt-compensated heading.
// ============================================================================
`default_nettype none

package tch_pkg;

    localparam int DataWidth  = 16;
    localparam int Frac       = DataWidth - 2;
    localparam int Iters      = DataWidth;
    localparam int AngW       = 34;
    localparam int ScW        = 17;
    localparam int ProdW      = 34;
    localparam int BfW        = 36;
    localparam int VecW       = 40;
    localparam int HeadW      = 15;
    localparam int FullCircle = 23040;
    localparam int DeclW      = 15;
    localparam logic signed [DeclW-1:0] DeclReset = -15'sd141;
    localparam logic [ScW-1:0] CordicGain = ScW'(((64'h9B74EDA8 +
        (64'd1 << (31 - Frac))) >> (32 - Frac)));
    localparam logic signed [AngW-1:0] QuarterTurn = 34'sh040000000;
    localparam logic signed [AngW-1:0] HalfTurn    = 34'sh080000000;

    function automatic logic signed [AngW-1:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0: v = 32'h20000000;   5'd1: v = 32'h12E4051E;
            5'd2: v = 32'h09FB385B;   5'd3: v = 32'h051111D4;
            5'd4: v = 32'h028B0D43;   5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E;   5'd7: v = 32'h00517C55;
            5'd8: v = 32'h0028BE53;   5'd9: v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;  5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;  5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;  5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;  5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;  5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;  5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return $signed({2'b00, v});
    endfunction

endpackage

`default_nettype wire

@@ sv/tilt_compensated_heading_top.sv @@
// ============================================================================
// tilt_compensated_heading_top
// Tilt-compensated compass heading with pipelined CORDIC stages.
// ============================================================================
//  channel | direction | payload
//  s_axis  | in        | tdata: roll, pitch, mag_x, mag_y, mag_z (80 bits)
//  m_axis  | out       | tdata: heading (15 bits, padded to 16)
//  cfg     | in        | declination (15 bits signed)
//
//  One word enters per cycle while the pipe advances; data passes through
//  two CORDIC chains (sin/cos then atan2), one stage per iteration.
//  The whole pipe advances only when the output slot is free or empty,
//  so a stall freezes every stage and nothing is lost or repeated.
//  Reset clears valid bits and sets the declination to -141.
`default_nettype none

module tilt_compensated_heading_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // roll[15:0], pitch[31:16], mag_x[47:32], mag_y[63:48], mag_z[79:64]
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // heading[14:0], zero pad [15]
    output logic [15:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [14:0] cfg_data
);
    localparam int N   = tch_pkg::Iters;
    localparam int AW  = tch_pkg::AngW;
    localparam int SW  = tch_pkg::ScW + 2;
    localparam int VW  = tch_pkg::VecW;
    localparam int NS  = 2 * N + 8;

    logic adv;
    logic [NS-1:0] vld_reg;

    assign adv = !vld_reg[NS-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = vld_reg[NS-1];

    logic signed [tch_pkg::DeclW-1:0] decl_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decl_reg <= tch_pkg::DeclReset;
        else if (cfg_valid)
            decl_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], s_axis_tvalid};
    end

    // Sine/cosine CORDIC for roll (r) and pitch (p), with magnetometer carried.
    logic signed [SW-1:0] rx_reg [N+1], ry_reg [N+1], px_reg [N+1], py_reg [N+1];
    logic signed [AW-1:0] rz_reg [N+1], pz_reg [N+1];
    logic rf_reg [N+1], pf_reg [N+1];
    logic signed [15:0] mx_reg [N+1], my_reg [N+1], mz_reg [N+1];

    function automatic void prep(input logic signed [15:0] a,
        output logic signed [AW-1:0] z, output logic f);
        z = AW'(a) <<< 16;
        f = 1'b0;
        if (a > 16'sd16384)
        begin
            z = z - tch_pkg::HalfTurn;
            f = 1'b1;
        end
        else if (a < -16'sd16384)
        begin
            z = z + tch_pkg::HalfTurn;
            f = 1'b1;
        end
    endfunction

    always_ff @(posedge clk)
    begin
        logic signed [AW-1:0] z0, z1;
        logic f0, f1;
        if (adv)
        begin
            prep($signed(s_axis_tdata[15:0]), z0, f0);
            prep($signed(s_axis_tdata[31:16]), z1, f1);
            rx_reg[0] <= $signed({2'b00, tch_pkg::CordicGain});
            px_reg[0] <= $signed({2'b00, tch_pkg::CordicGain});
            ry_reg[0] <= '0;
            py_reg[0] <= '0;
            rz_reg[0] <= z0;
            pz_reg[0] <= z1;
            rf_reg[0] <= f0;
            pf_reg[0] <= f1;
            mx_reg[0] <= $signed(s_axis_tdata[47:32]);
            my_reg[0] <= $signed(s_axis_tdata[63:48]);
            mz_reg[0] <= $signed(s_axis_tdata[79:64]);
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_sc
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!rz_reg[i][AW-1])
                begin
                    rx_reg[i+1] <= rx_reg[i] - (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] + (rx_reg[i] >>> i);
                    rz_reg[i+1] <= rz_reg[i] - tch_pkg::atan_lut(5'(i));
                end
                else
                begin
                    rx_reg[i+1] <= rx_reg[i] + (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] - (rx_reg[i] >>> i);
                    rz_reg[i+1] <= rz_reg[i] + tch_pkg::atan_lut(5'(i));
                end
                if (!pz_reg[i][AW-1])
                begin
                    px_reg[i+1] <= px_reg[i] - (py_reg[i] >>> i);
                    py_reg[i+1] <= py_reg[i] + (px_reg[i] >>> i);
                    pz_reg[i+1] <= pz_reg[i] - tch_pkg::atan_lut(5'(i));
                end
                else
                begin
                    px_reg[i+1] <= px_reg[i] + (py_reg[i] >>> i);
                    py_reg[i+1] <= py_reg[i] - (px_reg[i] >>> i);
                    pz_reg[i+1] <= pz_reg[i] + tch_pkg::atan_lut(5'(i));
                end
                rf_reg[i+1] <= rf_reg[i];
                pf_reg[i+1] <= pf_reg[i];
                mx_reg[i+1] <= mx_reg[i];
                my_reg[i+1] <= my_reg[i];
                mz_reg[i+1] <= mz_reg[i];
            end
        end
    end

    // Stage A: resolve flips and roll products. Stage B: sums, mx*cos. Stage C: t*sin. Stage D: bfx sum.
    logic signed [SW-1:0] sp_reg, cp_reg, sp2_reg;
    logic signed [15:0] mxa_reg;
    logic signed [tch_pkg::ProdW+1:0] p1_reg, p2_reg, p3_reg, p4_reg, pmx_reg;
    logic signed [tch_pkg::BfW-1:0] bfy_reg, bfy2_reg, t_reg, bfx_reg;
    logic signed [tch_pkg::BfW+SW:0] tsp;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp_reg <= pf_reg[N] ? -py_reg[N] : py_reg[N];
            cp_reg <= pf_reg[N] ? -px_reg[N] : px_reg[N];
            mxa_reg <= mx_reg[N];
            p1_reg <= 36'(mz_reg[N]) * 36'(rf_reg[N] ? -ry_reg[N] : ry_reg[N]);
            p2_reg <= 36'(my_reg[N]) * 36'(rf_reg[N] ? -rx_reg[N] : rx_reg[N]);
            p3_reg <= 36'(my_reg[N]) * 36'(rf_reg[N] ? -ry_reg[N] : ry_reg[N]);
            p4_reg <= 36'(mz_reg[N]) * 36'(rf_reg[N] ? -rx_reg[N] : rx_reg[N]);
            // stage B
            bfy_reg <= 36'(p1_reg - p2_reg);
            t_reg <= 36'((p3_reg + p4_reg) >>> tch_pkg::Frac);
            pmx_reg <= 36'(mxa_reg) * 36'(cp_reg);
            sp2_reg <= sp_reg;
            // stage C
            bfy2_reg <= bfy_reg;
        end
    end
    assign tsp = (tch_pkg::BfW + SW + 1)'(t_reg) * (tch_pkg::BfW + SW + 1)'(sp2_reg);

    logic signed [tch_pkg::BfW-1:0] pmx2_reg;
    logic signed [tch_pkg::BfW+SW:0] tsp_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tsp_reg <= tsp;
            pmx2_reg <= 36'(pmx_reg);
            bfx_reg <= 36'(pmx2_reg + tsp_reg);
        end
    end

    logic signed [tch_pkg::BfW-1:0] bfy3_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            bfy3_reg <= bfy2_reg;
    end

    // atan2 vectoring CORDIC on (-bfy, bfx).
    logic signed [VW-1:0] vx_reg [N+1], vy_reg [N+1];
    logic signed [AW-1:0] vz_reg [N+1];
    logic zero_reg [N+1];
    logic signed [VW-1:0] yv, xv;
    assign yv = -VW'(bfy3_reg);
    assign xv = VW'(bfx_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_reg[0] <= (xv == 0) && (yv == 0);
            vx_reg[0] <= xv;
            vy_reg[0] <= yv;
            vz_reg[0] <= '0;
            if (xv < 0)
            begin
                if (yv >= 0)
                begin
                    vx_reg[0] <= yv;
                    vy_reg[0] <= -xv;
                    vz_reg[0] <= tch_pkg::QuarterTurn;
                end
                else
                begin
                    vx_reg[0] <= -yv;
                    vy_reg[0] <= xv;
                    vz_reg[0] <= -tch_pkg::QuarterTurn;
                end
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_at
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (vy_reg[i] > 0)
                begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + tch_pkg::atan_lut(5'(i));
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - tch_pkg::atan_lut(5'(i));
                end
            end
        end
    end

    // Scale to 1/64 degree, then add declination and wrap.
    localparam int HeadW = tch_pkg::HeadW;
    logic [31:0] u;
    logic [47:0] hs_reg;
    logic [15:0] h;
    logic signed [16:0] sum;
    logic [HeadW-1:0] head_reg;
    assign u = zero_reg[N] ? 32'd0 : vz_reg[N][31:0];

    always_ff @(posedge clk)
    begin
        if (adv)
            hs_reg <= 48'(u) * 48'(tch_pkg::FullCircle) + 48'h80000000;
    end
    assign h = hs_reg[47:32];
    assign sum = 17'($signed({1'b0, h})) + 17'(decl_reg);

    always_ff @(posedge clk)
    begin
        logic signed [16:0] s;
        if (adv)
        begin
            s = sum;
            if (s < 0)
                s = s + 17'(tch_pkg::FullCircle);
            else if (s >= 17'(tch_pkg::FullCircle))
                s = s - 17'(tch_pkg::FullCircle);
            if (s >= 17'(tch_pkg::FullCircle))
                s = s - 17'(tch_pkg::FullCircle);
            head_reg <= HeadW'(s);
        end
    end
    assign m_axis_tdata = {1'b0, head_reg};

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (head_reg < 15'(tch_pkg::FullCircle)))
        else $error("heading out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_reg))
        else $error("pipe moved while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[NS-1] |-> s_axis_tready)
        else $error("input blocked with free output");

endmodule

`default_nettype wire
